// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tbstf_pkg.sv -----
// Shared types, codes and defaults for the serial transmit FIFO.
package tbstf_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 512;
  localparam int unsigned COPIES_DEF     = 3;
  localparam int unsigned DATA_W         = 8;

  typedef logic [1:0] op_t;

  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_CLOSE = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  localparam logic [2:0] BIT_MSB = 3'd7;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
  } in_item_t;

  // Packed so that serial_bit lands in bit 0.
  typedef struct packed {
    logic accepted;
    logic available;
    logic serial_bit;
  } result_t;

endpackage

// ----- src/tbstf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tbstf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/tbstf_core.sv -----
// Pointer, bit-shift and checksum control around the group store RAM.
module tbstf_core import tbstf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int unsigned COPIES     = COPIES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  in_item_t req_i,
  output result_t  res_o
);

  // Fill level in byte slots; never exceeds FIFO_DEPTH-1.
  localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned SUM_W   = CNT_W + 3;
  // Every write is COPIES identical bytes, so the RAM keeps one entry per group.
  localparam int unsigned GRP_RAW = (FIFO_DEPTH + COPIES - 2) / COPIES;
  localparam int unsigned GDEPTH  = (GRP_RAW < 2) ? 2 : GRP_RAW;
  localparam int unsigned GA_W    = $clog2(GDEPTH);
  localparam int unsigned CP_W    = (COPIES > 1) ? $clog2(COPIES) : 1;

  localparam logic [SUM_W-1:0] FILL_LIMIT = SUM_W'(FIFO_DEPTH - 1);
  localparam logic [SUM_W-1:0] COPIES_S   = SUM_W'(COPIES);
  localparam logic [GA_W-1:0]  GRP_LAST   = GA_W'(GDEPTH - 1);
  localparam logic [CP_W-1:0]  CP_LAST    = CP_W'(COPIES - 1);

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [GA_W-1:0]   rd_grp_q, rd_grp_d;
  logic [GA_W-1:0]   wr_grp_q, wr_grp_d;
  logic [CP_W-1:0]   rd_copy_q, rd_copy_d;
  logic [2:0]        bit_pos_q, bit_pos_d;
  logic [DATA_W-1:0] csum_q, csum_d;
  logic              fwd_q, fwd_d;
  logic [DATA_W-1:0] fwd_data_q;

  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] wr_value;
  logic [SUM_W-1:0]  fill_plus;
  logic              room;
  logic              we;
  result_t           res;

  tbstf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (GDEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_grp_q),
    .wdata_i (wr_value),
    .raddr_i (rd_grp_d),
    .rdata_o (ram_rdata)
  );

  // RAM read is old-data on a same-address write; take the written byte instead.
  assign head      = fwd_q ? fwd_data_q : ram_rdata;
  assign wr_value  = (req_i.op == OP_PUSH) ? req_i.data : csum_q;
  assign fill_plus = {3'b000, fill_q} + COPIES_S;
  assign room      = (fill_plus <= FILL_LIMIT);
  assign fwd_d     = we && (wr_grp_q == rd_grp_d);

  always_comb begin
    fill_d    = fill_q;
    rd_grp_d  = rd_grp_q;
    wr_grp_d  = wr_grp_q;
    rd_copy_d = rd_copy_q;
    bit_pos_d = bit_pos_q;
    csum_d    = csum_q;
    we        = 1'b0;
    res       = '0;
    if (req_valid_i) begin
      case (req_i.op)
        OP_PUSH, OP_CLOSE: begin
          if (room) begin
            we           = 1'b1;
            wr_grp_d     = (wr_grp_q == GRP_LAST) ? '0 : wr_grp_q + 1'b1;
            fill_d       = fill_plus[CNT_W-1:0];
            res.accepted = 1'b1;
            csum_d       = (req_i.op == OP_PUSH) ? (csum_q ^ req_i.data) : '0;
          end
        end
        OP_TICK: begin
          if (fill_q != '0) begin
            res.serial_bit = head[bit_pos_q];
            if (bit_pos_q == 3'd0) begin
              bit_pos_d = BIT_MSB;
              fill_d    = fill_q - 1'b1;
              // Step to the next group after its last copy.
              if (rd_copy_q == CP_LAST) begin
                rd_copy_d = '0;
                rd_grp_d  = (rd_grp_q == GRP_LAST) ? '0 : rd_grp_q + 1'b1;
              end else begin
                rd_copy_d = rd_copy_q + 1'b1;
              end
            end else begin
              bit_pos_d = bit_pos_q - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    res.available = (fill_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      rd_grp_q  <= '0;
      wr_grp_q  <= '0;
      rd_copy_q <= '0;
      bit_pos_q <= BIT_MSB;
      csum_q    <= '0;
      fwd_q     <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      rd_grp_q  <= rd_grp_d;
      wr_grp_q  <= wr_grp_d;
      rd_copy_q <= rd_copy_d;
      bit_pos_q <= bit_pos_d;
      csum_q    <= csum_d;
      fwd_q     <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_value;
  end

  assign res_o = res;

endmodule

// ----- src/tbstf_obuf.sv -----
// Two-entry result queue between the core and the output channel.
module tbstf_obuf import tbstf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_res_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic       push;
  logic       pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          slot0_d = in_res_i;
        end else begin
          slot1_d = in_res_i;
        end
        cnt_d = cnt_q + 1'b1;
      end
      2'b01: begin
        slot0_d = slot1_q;
        cnt_d   = cnt_q - 1'b1;
      end
      // Push only happens with one entry here: replace the departing head.
      2'b11: begin
        slot0_d = in_res_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_res_o = slot0_q;

endmodule

// ----- src/tripled_byte_serial_tx_fifo_top.sv -----
// Top level of the byte FIFO serial transmitter with frame checksum.
//
//  channel | dir | tdata                        | tuser
//  s_axis  | in  | [7:0] data_byte              | [1:0] operation
//  m_axis  | out | [0] serial_bit, [1] available, [2] accepted, [7:3] zero | -
//
// One item per cycle while the result queue has room: each transaction updates
// the pointers, fill level and bit position; the head group byte is prefetched
// from the RAM at the next read pointer, with forwarding for a same-entry write.
// Reset clears pointers, fill level and checksum and sets the bit position to 7;
// the RAM needs no clearing. Results pass through a two-entry queue, so input
// stalls only when two results wait on m_axis.
module tripled_byte_serial_tx_fifo_top import tbstf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int unsigned COPIES     = COPIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,  // [1:0] operation
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] serial_bit, [1] available, [2] accepted
);

  in_item_t req;
  result_t  core_res;
  result_t  out_res;
  logic     accept;

  assign req.op   = s_axis_tuser;
  assign req.data = s_axis_tdata;
  assign accept   = s_axis_tvalid && s_axis_tready;

  tbstf_core #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .COPIES     (COPIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_i       (req),
    .res_o       (core_res)
  );

  tbstf_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_res_i    (core_res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {5'b00000, out_res};

endmodule

// ----- src/tbstf_checker.sv -----
// Port-level checker for the serial transmit FIFO, bound to the top level.
`include "assert_macros.svh"

module tbstf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic in_txn;

  assign in_txn = s_axis_tvalid && s_axis_tready;

  `CHK_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `CHK_ALWAYS(a_pad_zero, clk_i, rst_ni, !m_axis_tvalid || (m_axis_tdata[7:3] == 5'd0), "result padding not zero")
  `CHK_ALWAYS(a_bit_not_write, clk_i, rst_ni, !m_axis_tvalid || !(m_axis_tdata[0] && m_axis_tdata[2]), "bit shifted on a write")
  `CHK_ALWAYS(a_write_avail, clk_i, rst_ni, !m_axis_tvalid || !m_axis_tdata[2] || m_axis_tdata[1], "accepted write left FIFO empty")
  `CHK_NEXT(a_stall_cause, clk_i, rst_ni, in_txn && !m_axis_tvalid, m_axis_tvalid, "transaction gave no result")

endmodule

bind tripled_byte_serial_tx_fifo_top tbstf_checker u_tbstf_checker (.*);

// ----- test/tb_tripled_byte_serial_tx_fifo_top.sv -----
// Self-checking testbench for the tripled-byte serial transmit FIFO top level.
`timescale 1ns / 100ps

module tb_tripled_byte_serial_tx_fifo_top;
  import tbstf_pkg::*;

  localparam int unsigned DEPTH = FIFO_DEPTH_DEF;
  localparam int unsigned NCOPY = COPIES_DEF;
  localparam op_t OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic [1:0] s_axis_tuser = 2'd0;   // [1:0] operation
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] serial_bit, [1] available, [2] accepted

  tripled_byte_serial_tx_fifo_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Transmitter state as the testbench sees it
  logic [7:0]  tx_ram [DEPTH];
  int unsigned tx_rd_ptr = 0;
  int unsigned tx_wr_ptr = 0;
  logic [2:0]  tx_bit_pos = BIT_MSB;
  logic [7:0]  tx_frame_sum = 8'h00;

  in_item_t pending_items[$];
  result_t  expected_results[$];
  in_item_t next_item;
  result_t  got_result;
  result_t  want_result;
  int       error_count = 0;
  int       cycle_count = 0;
  int       src_gap = 0;
  int       src_steady = 0;
  int       snk_gap = 0;
  int       snk_steady = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic store_copies(logic [7:0] value);
    int unsigned fill;
    fill = (tx_wr_ptr + DEPTH - tx_rd_ptr) % DEPTH;
    if (DEPTH - 1 - fill < NCOPY) return 1'b0;
    for (int k = 0; k < NCOPY; k++) begin
      tx_ram[tx_wr_ptr] = value;
      tx_wr_ptr = (tx_wr_ptr + 1) % DEPTH;
    end
    return 1'b1;
  endfunction

  function automatic result_t transmit_step(in_item_t it);
    result_t res;
    res = '0;
    case (it.op)
      OP_PUSH: begin
        if (store_copies(it.data)) begin
          tx_frame_sum = tx_frame_sum ^ it.data;
          res.accepted = 1'b1;
        end
      end
      OP_CLOSE: begin
        if (store_copies(tx_frame_sum)) begin
          tx_frame_sum = 8'h00;
          res.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (tx_rd_ptr != tx_wr_ptr) begin
          res.serial_bit = tx_ram[tx_rd_ptr][tx_bit_pos];
          if (tx_bit_pos == 3'd0) begin
            tx_bit_pos = BIT_MSB;
            tx_rd_ptr = (tx_rd_ptr + 1) % DEPTH;
          end else begin
            tx_bit_pos = tx_bit_pos - 3'd1;
          end
        end
      end
      default: ;
    endcase
    res.available = (tx_rd_ptr != tx_wr_ptr);
    return res;
  endfunction

  task automatic add_item(op_t op, logic [7:0] data);
    in_item_t it;
    it.op = op;
    it.data = data;
    pending_items.push_back(it);
  endtask

  task automatic add_random_items(int count, int tick_pct, int push_pct, int close_pct);
    int r;
    op_t op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) op = OP_TICK;
      else if (r < tick_pct + push_pct) op = OP_PUSH;
      else if (r < tick_pct + push_pct + close_pct) op = OP_CLOSE;
      else op = OP_RESERVED;
      add_item(op, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    error_count++;
  endtask

  // Driver: advance to the next pending item once the current transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 2'd0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        next_item.op = s_axis_tuser;
        next_item.data = s_axis_tdata;
        expected_results.push_back(transmit_step(next_item));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.data;
          s_axis_tuser  <= next_item.op;
          if (src_steady > 0) src_steady = src_steady - 1;
          else if ($urandom_range(0, 99) == 0) src_steady = $urandom_range(40, 120);
          src_gap = (src_steady > 0) ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result %0h arrived with no expectation, expected none", $time,
                   m_axis_tdata);
          error_count++;
        end else begin
          want_result = expected_results.pop_front();
          got_result = m_axis_tdata[2:0];
          if (got_result.serial_bit !== want_result.serial_bit)
            report_mismatch("serial_bit", want_result.serial_bit, got_result.serial_bit);
          if (got_result.available !== want_result.available)
            report_mismatch("available", want_result.available, got_result.available);
          if (got_result.accepted !== want_result.accepted)
            report_mismatch("accepted", want_result.accepted, got_result.accepted);
          if (m_axis_tdata[7:3] !== 5'd0)
            report_mismatch("tdata padding", 0, m_axis_tdata[7:3]);
        end
        if (snk_steady > 0) snk_steady = snk_steady - 1;
        else if ($urandom_range(0, 99) == 0) snk_steady = $urandom_range(40, 120);
        snk_gap = (snk_steady > 0) ? 0 : pick_gap();
      end
      if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL tripled_byte_serial_tx_fifo_top");
      $finish;
    end
  end

  initial begin
    // Tick on empty, reserved op, push then immediate tick on a just-written entry
    add_item(OP_TICK, 8'h5A);
    add_item(OP_RESERVED, 8'hFF);
    add_item(OP_PUSH, 8'hFF);
    add_item(OP_TICK, 8'h00);
    add_item(OP_PUSH, 8'h00);
    add_item(OP_PUSH, 8'h80);
    add_item(OP_PUSH, 8'h01);
    add_item(OP_CLOSE, 8'hC3);
    // Checksum was just cleared, so this frame closes with zeros
    add_item(OP_CLOSE, 8'h3C);
    add_item(OP_RESERVED, 8'h00);
    for (int i = 0; i < 15; i++) add_item(OP_TICK, 8'($urandom_range(0, 255)));

    // Near-empty random walk, then fill past full, then shift out with sparse writes
    add_random_items(200, 95, 3, 1);
    add_random_items(250, 8, 75, 15);
    add_random_items(700, 88, 8, 3);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS tripled_byte_serial_tx_fifo_top");
    end else begin
      $display("FAIL tripled_byte_serial_tx_fifo_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/tbstf_pkg.sv
src/tbstf_ram.sv
src/tbstf_core.sv
src/tbstf_obuf.sv
src/tripled_byte_serial_tx_fifo_top.sv
src/tbstf_checker.sv
test/tb_tripled_byte_serial_tx_fifo_top.sv
